// ===== hdl/pip_pkg.sv =====
package pip_pkg;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int COORD_WIDTH_DEF  = 24;
  localparam int KIND_W           = 2;
  localparam int QUEUE_DEPTH      = 4;

  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_QUERY
  } op_t;

  typedef struct packed {
    logic vld;
    logic rdy;
  } hs_t;

endpackage

// ===== hdl/pip_front.sv =====
module pip_front #(
  parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  output logic                          in_rdy,
  input  logic [pip_pkg::KIND_W-1:0]    in_kind,
  input  logic [COORD_WIDTH-1:0]        in_x,
  input  logic [COORD_WIDTH-1:0]        in_y,
  input  logic                          pop,
  output pip_pkg::hs_t                  q_hs,
  output pip_pkg::op_t                  q_op,
  output logic [COORD_WIDTH-1:0]        q_x,
  output logic [COORD_WIDTH-1:0]        q_y
);
  import pip_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  op_t                    op_mem [QUEUE_DEPTH];
  logic [COORD_WIDTH-1:0] x_mem  [QUEUE_DEPTH];
  logic [COORD_WIDTH-1:0] y_mem  [QUEUE_DEPTH];
  logic [PW-1:0]          wr_ptr_r, rd_ptr_r;
  logic [PW:0]            cnt_r, cnt_nxt;
  logic                   push, do_pop, known;
  op_t                    op_dec;

  always_comb begin
    known  = 1'b1;
    op_dec = OP_CLEAR;
    unique case (in_kind)
      KIND_CLEAR:  op_dec = OP_CLEAR;
      KIND_APPEND: op_dec = OP_APPEND;
      KIND_QUERY:  op_dec = OP_QUERY;
      default:     known  = 1'b0;
    endcase
  end

  assign in_rdy  = (cnt_r != (PW+1)'(QUEUE_DEPTH));
  assign push    = in_vld && in_rdy && known;
  assign do_pop  = pop && (cnt_r != '0);
  assign cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(do_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push)   wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      op_mem[wr_ptr_r] <= op_dec;
      x_mem[wr_ptr_r]  <= in_x;
      y_mem[wr_ptr_r]  <= in_y;
    end
  end

  assign q_hs.vld = (cnt_r != '0);
  assign q_hs.rdy = pop;
  assign q_op     = op_mem[rd_ptr_r];
  assign q_x      = x_mem[rd_ptr_r];
  assign q_y      = y_mem[rd_ptr_r];

endmodule

// ===== hdl/pip_back.sv =====
module pip_back #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pip_pkg::hs_t           q_hs,
  input  pip_pkg::op_t           q_op,
  input  logic [COORD_WIDTH-1:0] q_x,
  input  logic [COORD_WIDTH-1:0] q_y,
  output logic                   pop,
  output logic                   res_vld,
  input  logic                   res_rdy,
  output logic                   res_inside
);
  import pip_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int PW = 2 * W + 2;
  localparam int SW = 2 * W + 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t state_r;

  logic [W-1:0] mem_x [MAX_VERTICES];
  logic [W-1:0] mem_y [MAX_VERTICES];

  logic [CW-1:0]       count_r, issue_r;
  logic signed [W-1:0] qx_r, qy_r;
  logic                odd_r, out_vld_r, out_bit_r;

  logic                we, rd_en;
  logic [AW-1:0]       rd_addr;

  logic                rd_vld_r, rd_first_r;
  logic signed [W-1:0] rd_x_r, rd_y_r, pv_x_r, pv_y_r;

  logic                e_vld_r, e_cond_r, e_sneg_r;
  logic signed [W:0]   e_dxa_r, e_span_r, e_dqy_r, e_dbx_r;
  logic signed [W:0]   dxa, span, dqy, dbx;
  logic                cond;

  logic                p_vld_r, p_cond_r, p_sneg_r;
  logic signed [PW-1:0] p1_r, p2_r;
  logic signed [SW-1:0] sum;
  logic                hit, pipe_busy, out_free;

  assign pop       = (state_r == ST_IDLE) && q_hs.vld;
  assign we        = pop && (q_op == OP_APPEND) && (count_r < CW'(MAX_VERTICES));
  assign rd_en     = (state_r == ST_WALK);
  assign rd_addr   = (issue_r == count_r) ? '0 : issue_r[AW-1:0];
  assign pipe_busy = rd_vld_r || e_vld_r || p_vld_r;
  assign out_free  = !out_vld_r || res_rdy;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_x[count_r[AW-1:0]] <= q_x;
      mem_y[count_r[AW-1:0]] <= q_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_x_r <= mem_x[rd_addr];
      rd_y_r <= mem_y[rd_addr];
    end
  end

  // edge a = previous vertex, b = vertex just read
  always_comb begin
    dxa  = {pv_x_r[W-1], pv_x_r} - {qx_r[W-1], qx_r};
    span = {rd_y_r[W-1], rd_y_r} - {pv_y_r[W-1], pv_y_r};
    dqy  = {qy_r[W-1], qy_r} - {pv_y_r[W-1], pv_y_r};
    dbx  = {rd_x_r[W-1], rd_x_r} - {pv_x_r[W-1], pv_x_r};
    cond = ((pv_y_r <= qy_r) && (rd_y_r > qy_r)) || ((pv_y_r > qy_r) && (rd_y_r <= qy_r));
  end

  assign sum = {p1_r[PW-1], p1_r} + {p2_r[PW-1], p2_r};
  assign hit = p_vld_r && p_cond_r && (sum != '0) && (sum[SW-1] == p_sneg_r);

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      pv_x_r <= rd_x_r;
      pv_y_r <= rd_y_r;
    end
    e_dxa_r  <= dxa;
    e_span_r <= span;
    e_dqy_r  <= dqy;
    e_dbx_r  <= dbx;
    e_cond_r <= cond;
    e_sneg_r <= span[W];
    p1_r     <= e_dxa_r * e_span_r;
    p2_r     <= e_dqy_r * e_dbx_r;
    p_cond_r <= e_cond_r;
    p_sneg_r <= e_sneg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      rd_first_r <= 1'b0;
      e_vld_r    <= 1'b0;
      p_vld_r    <= 1'b0;
    end else begin
      rd_vld_r   <= rd_en;
      rd_first_r <= rd_en && (issue_r == '0);
      e_vld_r    <= rd_vld_r && !rd_first_r;
      p_vld_r    <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      issue_r   <= '0;
      odd_r     <= 1'b0;
      out_vld_r <= 1'b0;
      out_bit_r <= 1'b0;
      qx_r      <= '0;
      qy_r      <= '0;
    end else begin
      if (res_rdy) out_vld_r <= 1'b0;
      if (hit)     odd_r     <= !odd_r;
      unique case (state_r)
        ST_IDLE: begin
          if (pop) begin
            unique case (q_op)
              OP_CLEAR:  count_r <= '0;
              OP_APPEND: if (we) count_r <= count_r + 1'b1;
              OP_QUERY: begin
                qx_r    <= q_x;
                qy_r    <= q_y;
                odd_r   <= 1'b0;
                issue_r <= '0;
                state_r <= (count_r == '0) ? ST_FINISH : ST_WALK;
              end
              default: ;
            endcase
          end
        end
        ST_WALK: begin
          issue_r <= issue_r + 1'b1;
          if (issue_r == count_r) state_r <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (!pipe_busy) state_r <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_vld_r <= 1'b1;
            out_bit_r <= odd_r;
            state_r   <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign res_vld    = out_vld_r;
  assign res_inside = out_bit_r;

endmodule

// ===== hdl/point_in_polygon_crossing_test_core.sv =====
// Point-in-polygon test by ray casting. Each input word clears the polygon, appends a vertex
// (ignored once MAX_VERTICES are held) or queries a point; only a query returns a word, with
// bit 0 set when the point is inside (odd number of edge crossings). The kind travels on
// in_tuser; kind 3 is accepted and dropped. Input words pass through a four-entry command
// queue, so the input side keeps taking words while a query is walking. Clear and append hold
// the executor for one cycle. A query holds it while the vertex memory delivers one vertex,
// hence one edge, per cycle (vertex_count + 1 reads) and the edge pipeline (difference,
// multiply, sum) fills and drains, and then until the output is free to take its word.
// An empty polygon skips the walk and answers outside.
module point_in_polygon_crossing_test_core #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  // kind[1:0]
  input  logic [pip_pkg::KIND_W-1:0]                    in_tuser,
  // coord_x, coord_y, zero fill
  input  logic [((2 * COORD_WIDTH + 7) / 8) * 8 - 1:0]  in_tdata,
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  // inside_res[0], zero fill
  output logic [7:0]                                    out_tdata
);
  import pip_pkg::*;

  localparam int W = COORD_WIDTH;

  hs_t         q_hs;
  op_t         q_op;
  logic [W-1:0] q_x, q_y;
  logic        pop, inside_bit;

  pip_front #(
    .COORD_WIDTH (W)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_tvalid),
    .in_rdy  (in_tready),
    .in_kind (in_tuser),
    .in_x    (in_tdata[W-1:0]),
    .in_y    (in_tdata[2*W-1:W]),
    .pop     (pop),
    .q_hs    (q_hs),
    .q_op    (q_op),
    .q_x     (q_x),
    .q_y     (q_y)
  );

  pip_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_hs       (q_hs),
    .q_op       (q_op),
    .q_x        (q_x),
    .q_y        (q_y),
    .pop        (pop),
    .res_vld    (out_tvalid),
    .res_rdy    (out_tready),
    .res_inside (inside_bit)
  );

  assign out_tdata = {7'd0, inside_bit};

endmodule
